/* rtl/assert_macros.svh */
// Assertion macros shared by the LED fade and blink controller modules.
// Included by each module that checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define LFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define LFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define LFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/lfb_pkg.sv */
// Shared types and constants for the LED fade and blink controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package lfb_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int LEVEL_W       = 8;
    localparam int DUR_W         = 32;
    localparam int OPC_W         = 3;
    localparam int CH_NUM        = 3;
    localparam int CH_W          = 2;
    localparam int PROD_W        = LEVEL_W + DUR_W;
    localparam int IN_DATA_W     = CH_NUM * LEVEL_W + DUR_W;
    localparam int OUT_DATA_W    = CH_NUM * LEVEL_W;

    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    typedef enum logic [OPC_W-1:0] {
        OP_TICK  = 3'd0,
        OP_SET   = 3'd1,
        OP_FADE  = 3'd2,
        OP_BLINK = 3'd3,
        OP_CLEAR = 3'd4
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FADE_CHECK,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_BLINK_START,
        ST_BLINK_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic            in_load;
        logic            time_inc;
        logic            colour_set;
        logic            mode_clear;
        logic            fade_arm;
        logic            blink_arm;
        logic            mul_load;
        logic            div_fade_start;
        logic            div_blink_start;
        logic            fade_write;
        logic            blink_apply;
        logic            refresh_we;
        logic            refresh_val;
        logic            out_load;
        logic [CH_W-1:0] chan;
    } cmd_t;

    typedef struct packed {
        opcode_t opcode;
        logic    led_en;
        logic    fade_on;
        logic    blink_on;
        logic    fade_over;
        logic    div_busy;
        logic    out_free;
    } status_t;

endpackage

/* rtl/lfb_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by fade and blink.
// Depends on lfb_pkg for widths.
`timescale 1ns / 1ps
module lfb_divider
    import lfb_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [DUR_W-1:0]                 rem_init,
    input  logic [TIME_BITS-1:0]             bits_init,
    input  logic [$clog2(TIME_BITS+1)-1:0]   steps,
    input  logic [DUR_W-1:0]                 divisor,
    output logic                             busy,
    output logic [LEVEL_W-1:0]               quot
);

    localparam int STEP_W = $clog2(TIME_BITS + 1);

    logic [STEP_W-1:0]    count_reg;
    logic [STEP_W-1:0]    count_next;
    logic [DUR_W-1:0]     rem_reg;
    logic [DUR_W-1:0]     rem_next;
    logic [TIME_BITS-1:0] bits_reg;
    logic [TIME_BITS-1:0] bits_next;
    logic [LEVEL_W-1:0]   quot_reg;
    logic [LEVEL_W-1:0]   quot_next;
    logic [DUR_W-1:0]     divisor_reg;
    logic [DUR_W-1:0]     divisor_next;
    logic [DUR_W:0]       shifted;
    logic [DUR_W+1:0]     trial;
    logic                 borrow;

    assign busy    = (count_reg != '0);
    assign quot    = quot_reg;
    assign shifted = {rem_reg, bits_reg[TIME_BITS-1]};
    assign trial   = {1'b0, shifted} - {2'b00, divisor_reg};
    assign borrow  = trial[DUR_W+1];

    always_comb
    begin
        count_next   = count_reg;
        rem_next     = rem_reg;
        bits_next    = bits_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            count_next   = steps;
            rem_next     = rem_init;
            bits_next    = bits_init;
            quot_next    = '0;
            divisor_next = divisor;
        end
        else if (busy)
        begin
            // partial remainder stays below the divisor, so 32 bits hold it
            count_next = count_reg - STEP_W'(1);
            rem_next   = borrow ? shifted[DUR_W-1:0] : trial[DUR_W-1:0];
            bits_next  = {bits_reg[TIME_BITS-2:0], 1'b0};
            quot_next  = {quot_reg[LEVEL_W-2:0], ~borrow};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        bits_reg    <= bits_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

endmodule

/* rtl/lfb_datapath.sv */
// Datapath: LED state, millisecond counter, fade multiplier, output register.
// Depends on lfb_pkg and lfb_divider; driven by lfb_ctrl through cmd_t.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lfb_datapath
    import lfb_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [OPC_W-1:0]      s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    input  cmd_t                  cmd,
    output status_t               sts
);

    localparam int CMP_W  = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
    localparam int STEP_W = $clog2(TIME_BITS + 1);

    logic                  led_en_reg;
    logic [TIME_BITS-1:0]  time_reg;
    logic [TIME_BITS-1:0]  fade_begin_reg;
    logic [DUR_W-1:0]      fade_len_reg;
    logic [DUR_W-1:0]      blink_per_reg;
    logic [LEVEL_W-1:0]    captured_reg [CH_NUM];
    logic [LEVEL_W-1:0]    shown_reg [CH_NUM];
    logic                  refresh_reg;
    opcode_t               opc_reg;
    logic [LEVEL_W-1:0]    in_level_reg [CH_NUM];
    logic [DUR_W-1:0]      dur_reg;
    logic [DUR_W-1:0]      elapsed_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tuser_reg;

    logic [TIME_BITS-1:0]  elapsed;
    logic [CMP_W-1:0]      elapsed_ext;
    logic [CMP_W-1:0]      len_ext;
    logic                  div_start;
    logic [DUR_W-1:0]      div_rem_init;
    logic [TIME_BITS-1:0]  div_bits_init;
    logic [STEP_W-1:0]     div_steps;
    logic [DUR_W-1:0]      div_divisor;
    logic                  div_busy;
    logic [LEVEL_W-1:0]    div_quot;

    // elapsed time wraps with the counter
    assign elapsed     = time_reg - fade_begin_reg;
    assign elapsed_ext = CMP_W'(elapsed);
    assign len_ext     = CMP_W'(fade_len_reg);

    // fade: top of the product seeds the remainder, the low byte is shifted in
    assign div_start     = cmd.div_fade_start | cmd.div_blink_start;
    assign div_rem_init  = cmd.div_fade_start ? prod_reg[PROD_W-1:LEVEL_W] : '0;
    assign div_bits_init = cmd.div_fade_start
                         ? (TIME_BITS'(prod_reg[LEVEL_W-1:0]) << (TIME_BITS - LEVEL_W))
                         : time_reg;
    assign div_steps     = cmd.div_fade_start ? STEP_W'(LEVEL_W) : STEP_W'(TIME_BITS);
    assign div_divisor   = cmd.div_fade_start ? fade_len_reg : blink_per_reg;

    lfb_divider #(
        .TIME_BITS (TIME_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .rem_init  (div_rem_init),
        .bits_init (div_bits_init),
        .steps     (div_steps),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quot      (div_quot)
    );

    always_comb
    begin
        sts.opcode    = opc_reg;
        sts.led_en    = led_en_reg;
        sts.fade_on   = (fade_len_reg != '0);
        sts.blink_on  = (blink_per_reg != '0);
        sts.fade_over = (elapsed_ext > len_ext);
        sts.div_busy  = div_busy;
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_en_reg     <= 1'b0;
            time_reg       <= '0;
            fade_begin_reg <= '0;
            fade_len_reg   <= '0;
            blink_per_reg  <= '0;
            refresh_reg    <= 1'b0;
            for (int ch = 0; ch < CH_NUM; ch++)
            begin
                captured_reg[ch] <= '0;
                shown_reg[ch]    <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                led_en_reg <= cfg_wdata;
            end
            if (cmd.time_inc)
            begin
                time_reg <= time_reg + TIME_BITS'(1);
            end
            if (cmd.fade_arm)
            begin
                fade_begin_reg <= time_reg;
                fade_len_reg   <= dur_reg;
            end
            if (cmd.blink_arm)
            begin
                blink_per_reg <= dur_reg;
            end
            if (cmd.mode_clear)
            begin
                fade_len_reg  <= '0;
                blink_per_reg <= '0;
            end
            if (cmd.fade_arm || cmd.blink_arm)
            begin
                for (int ch = 0; ch < CH_NUM; ch++)
                begin
                    captured_reg[ch] <= shown_reg[ch];
                end
            end
            priority if (cmd.colour_set)
            begin
                for (int ch = 0; ch < CH_NUM; ch++)
                begin
                    shown_reg[ch] <= in_level_reg[ch];
                end
            end
            else if (cmd.mode_clear)
            begin
                for (int ch = 0; ch < CH_NUM; ch++)
                begin
                    shown_reg[ch] <= '0;
                end
            end
            else if (cmd.fade_write)
            begin
                shown_reg[cmd.chan] <= captured_reg[cmd.chan] - div_quot;
            end
            else if (cmd.blink_apply)
            begin
                for (int ch = 0; ch < CH_NUM; ch++)
                begin
                    shown_reg[ch] <= div_quot[0] ? '0 : captured_reg[ch];
                end
            end
            if (cmd.refresh_we)
            begin
                refresh_reg <= cmd.refresh_val;
            end
        end
    end

    // transaction capture and fade arithmetic, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            opc_reg <= opcode_t'(s_tuser);
            for (int ch = 0; ch < CH_NUM; ch++)
            begin
                in_level_reg[ch] <= s_tdata[ch*LEVEL_W +: LEVEL_W];
            end
            dur_reg <= s_tdata[CH_NUM*LEVEL_W +: DUR_W];
        end
        elapsed_reg <= elapsed_ext[DUR_W-1:0];
        if (cmd.mul_load)
        begin
            prod_reg <= PROD_W'(captured_reg[cmd.chan]) * PROD_W'(elapsed_reg);
        end
    end

    // output register: holds one result while the next transaction is worked on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {shown_reg[CH_BLUE], shown_reg[CH_GREEN], shown_reg[CH_RED]};
            m_tuser_reg <= refresh_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `LFB_ASSERT_IMPLY(a_fade_quot_bound, clk, rst_n, cmd.fade_write, div_quot <= captured_reg[cmd.chan], "fade quotient exceeds captured level")
    `LFB_ASSERT_NEXT(a_out_loaded, clk, rst_n, cmd.out_load, m_tvalid_reg, "result not presented after load")

endmodule

/* rtl/lfb_ctrl.sv */
// Controller state machine: decodes each transaction and sequences the datapath.
// Depends on lfb_pkg; talks to lfb_datapath through cmd_t and status_t.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lfb_ctrl
    import lfb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t          state_reg;
    state_t          state_next;
    logic [CH_W-1:0] chan_reg;
    logic [CH_W-1:0] chan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= CH_RED;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.opcode == OP_TICK && sts.led_en && sts.fade_on)
                begin
                    state_next = ST_FADE_CHECK;
                end
                else if (sts.opcode == OP_TICK && sts.led_en && sts.blink_on)
                begin
                    state_next = ST_BLINK_START;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_FADE_CHECK:
            begin
                chan_next  = CH_RED;
                state_next = sts.fade_over ? ST_OUT : ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    if (chan_reg == CH_BLUE)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        chan_next  = chan_reg + CH_W'(1);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_BLINK_START:
            begin
                state_next = ST_BLINK_WAIT;
            end
            ST_BLINK_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.chan = chan_reg;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.in_load = s_tvalid;
            end
            ST_DECODE:
            begin
                cmd.refresh_we = 1'b1;
                unique case (sts.opcode)
                    OP_TICK:
                    begin
                        cmd.time_inc = 1'b1;
                    end
                    OP_SET:
                    begin
                        cmd.colour_set  = sts.led_en;
                        cmd.mode_clear  = sts.led_en;
                        cmd.refresh_val = sts.led_en;
                    end
                    OP_FADE:
                    begin
                        cmd.fade_arm = 1'b1;
                    end
                    OP_BLINK:
                    begin
                        cmd.blink_arm = 1'b1;
                    end
                    OP_CLEAR:
                    begin
                        cmd.mode_clear  = 1'b1;
                        cmd.refresh_val = sts.led_en;
                    end
                    default:
                    begin
                        // unused opcodes: drop
                        cmd.refresh_val = 1'b0;
                    end
                endcase
            end
            ST_FADE_CHECK:
            begin
                // past the end of the fade: go dark and stop both modes
                cmd.mode_clear  = sts.fade_over;
                cmd.refresh_we  = sts.fade_over;
                cmd.refresh_val = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
            end
            ST_DIV_START:
            begin
                cmd.div_fade_start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                cmd.fade_write  = !sts.div_busy;
                cmd.refresh_we  = !sts.div_busy && (chan_reg == CH_BLUE);
                cmd.refresh_val = 1'b1;
            end
            ST_BLINK_START:
            begin
                cmd.div_blink_start = 1'b1;
            end
            ST_BLINK_WAIT:
            begin
                cmd.blink_apply = !sts.div_busy;
                cmd.refresh_we  = !sts.div_busy;
                cmd.refresh_val = 1'b1;
            end
            ST_OUT:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd.refresh_we = 1'b0;
            end
        endcase
    end

    `LFB_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready, "second transaction taken while busy")
    `LFB_ASSERT_NEXT(a_div_runs, clk, rst_n, cmd.div_fade_start || cmd.div_blink_start, sts.div_busy, "divider did not start")
    `LFB_ASSERT_IMPLY(a_fade_needs_mode, clk, rst_n, state_reg == ST_FADE_CHECK, sts.fade_on && sts.led_en, "fade evaluated with fade off or LED disabled")

endmodule

/* rtl/led_fade_blink_controller_core.sv */
// Top level of the RGB status LED fade and blink controller.
// Depends on lfb_pkg, lfb_ctrl and lfb_datapath (which holds lfb_divider).
`timescale 1ns / 1ps
// Takes one command transaction at a time and returns exactly one result per
// transaction through an output register, so a waiting result does not block
// acceptance of the next command. Set, fade, blink and clear, unused opcodes and
// ticks with no active fade or blink go from decode straight to the output
// state. A tick that runs past the end of a fade first passes the fade check.
// A tick during a fade, after the fade check, works each colour channel in turn:
// an 8x32 multiply, a divider start and an 8-step shift-subtract division by the
// fade length, then a write of the level back. A tick during a blink uses the
// same bit-serial divider to divide the counter by the blink period and find the
// phase bit. A result still held in the output register while m_tready is low
// stalls the next result. The enable register may be written on any cycle the
// block is idle.
module led_fade_blink_controller_core
    import lfb_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,   // led_enabled
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,     // red_in, green_in, blue_in, duration_ms
    input  logic [OPC_W-1:0]      s_tuser,     // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,     // red_out, green_out, blue_out
    output logic                  m_tuser      // refreshed
);

    cmd_t    cmd;
    status_t sts;

    lfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lfb_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* sim/tb_led_fade_blink_controller_core.sv */
// Self-checking testbench for led_fade_blink_controller_core: directed and random command
// streams against a behavioural LED model, with random input bursts and output stalls.
// Depends on lfb_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_led_fade_blink_controller_core;
    import lfb_pkg::*;

    localparam logic [OPC_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam int QUIET_LIMIT = 4000;

    typedef struct {
        logic [OPC_W-1:0]   op;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic [DUR_W-1:0]   span;
    } led_cmd_t;

    typedef struct {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic               refreshed;
    } led_view_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;    // red_in, green_in, blue_in, duration_ms
    logic [OPC_W-1:0]      s_tuser = '0;    // opcode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // red_out, green_out, blue_out
    logic                  m_tuser;         // refreshed

    led_cmd_t  cmd_pending[$];
    led_view_t led_expected[$];
    led_cmd_t  drive_cmd;
    led_cmd_t  seen_cmd;
    led_view_t want_view;
    logic      in_accepted = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;
    rx_mode_t  rx_mode = RX_OPEN;
    int        rx_left = 0;
    logic [7:0] rx_tick = '0;
    int        quiet_cycles = 0;
    int        mismatches = 0;
    int        queued_cmds = 0;

    // LED model state
    logic                      led_on = 1'b0;
    logic [TIME_BITS_DEF-1:0]  clock_ms = '0;
    logic [TIME_BITS_DEF-1:0]  fade_start = '0;
    logic [DUR_W-1:0]          fade_len = '0;
    logic [DUR_W-1:0]          blink_len = '0;
    logic [LEVEL_W-1:0]        captured[CH_NUM];
    logic [LEVEL_W-1:0]        shown[CH_NUM];

    led_fade_blink_controller_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void blank_led();
        for (int ch = 0; ch < CH_NUM; ch++)
        begin
            shown[ch] = '0;
        end
        fade_len  = '0;
        blink_len = '0;
    endfunction

    // Apply one command to the model and return the colour it leaves on the LED.
    function automatic led_view_t led_apply(led_cmd_t c);
        led_view_t                v;
        logic [TIME_BITS_DEF-1:0] elapsed;
        logic [TIME_BITS_DEF-1:0] slot;
        logic [63:0]              scaled;
        v.refreshed = 1'b0;
        case (c.op)
            OP_TICK:
            begin
                clock_ms = clock_ms + 1'b1;
                if (led_on && fade_len != 0)
                begin
                    v.refreshed = 1'b1;
                    elapsed = clock_ms - fade_start;
                    if (elapsed > fade_len)
                    begin
                        blank_led();
                    end
                    else
                    begin
                        for (int ch = 0; ch < CH_NUM; ch++)
                        begin
                            scaled = 64'(captured[ch]) * 64'(elapsed);
                            shown[ch] = captured[ch] - LEVEL_W'(scaled / 64'(fade_len));
                        end
                    end
                end
                else if (led_on && blink_len != 0)
                begin
                    v.refreshed = 1'b1;
                    slot = clock_ms / blink_len;
                    for (int ch = 0; ch < CH_NUM; ch++)
                    begin
                        shown[ch] = slot[0] ? '0 : captured[ch];
                    end
                end
            end
            OP_SET:
            begin
                if (led_on)
                begin
                    blank_led();
                    shown[CH_RED]   = c.red;
                    shown[CH_GREEN] = c.green;
                    shown[CH_BLUE]  = c.blue;
                    v.refreshed = 1'b1;
                end
            end
            OP_FADE:
            begin
                captured   = shown;
                fade_start = clock_ms;
                fade_len   = c.span;
            end
            OP_BLINK:
            begin
                captured  = shown;
                blink_len = c.span;
            end
            OP_CLEAR:
            begin
                blank_led();
                v.refreshed = led_on;
            end
            default:
            begin
            end
        endcase
        v.red   = shown[CH_RED];
        v.green = shown[CH_GREEN];
        v.blue  = shown[CH_BLUE];
        return v;
    endfunction

    function automatic void check_field(string name, logic [LEVEL_W-1:0] want,
                                        logic [LEVEL_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Monitor: model update on each accepted command, compare on each accepted result
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_accepted <= 1'b0;
            led_on     = 1'b0;
            clock_ms   = '0;
            fade_start = '0;
            fade_len   = '0;
            blink_len  = '0;
            for (int ch = 0; ch < CH_NUM; ch++)
            begin
                captured[ch] = '0;
                shown[ch]    = '0;
            end
        end
        else
        begin
            in_accepted <= s_tvalid && s_tready;
            if (cfg_we)
            begin
                led_on = cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                seen_cmd.op    = s_tuser;
                seen_cmd.red   = s_tdata[LEVEL_W-1:0];
                seen_cmd.green = s_tdata[2*LEVEL_W-1:LEVEL_W];
                seen_cmd.blue  = s_tdata[3*LEVEL_W-1:2*LEVEL_W];
                seen_cmd.span  = s_tdata[IN_DATA_W-1:3*LEVEL_W];
                led_expected.push_back(led_apply(seen_cmd));
            end
            if (m_tvalid && m_tready)
            begin
                if (led_expected.size() == 0)
                begin
                    $error("result with no command outstanding: rgb %h refreshed %b",
                           m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want_view = led_expected.pop_front();
                    check_field("red_out", want_view.red, m_tdata[LEVEL_W-1:0]);
                    check_field("green_out", want_view.green, m_tdata[2*LEVEL_W-1:LEVEL_W]);
                    check_field("blue_out", want_view.blue, m_tdata[3*LEVEL_W-1:2*LEVEL_W]);
                    check_field("refreshed", LEVEL_W'(want_view.refreshed), LEVEL_W'(m_tuser));
                end
            end
        end
    end

    // Driver: send queued commands in bursts, with random gaps between bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_accepted)
        begin
            if (gap_left != 0 || cmd_pending.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left != 0)
                begin
                    gap_left--;
                end
            end
            else
            begin
                drive_cmd = cmd_pending.pop_front();
                s_tuser  <= drive_cmd.op;
                s_tdata  <= {drive_cmd.span, drive_cmd.blue, drive_cmd.green, drive_cmd.red};
                s_tvalid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                end
                burst_left--;
                if (burst_left == 0)
                begin
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
    end

    // Result side: stall on a pattern that switches mode at random intervals
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(40, 250);
        end
        else
        begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_tready <= ($urandom_range(0, 7) == 0);
            default:     m_tready <= (rx_tick[2:0] < 3'd5);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_cmd(logic [OPC_W-1:0] op, logic [LEVEL_W-1:0] r,
                             logic [LEVEL_W-1:0] g, logic [LEVEL_W-1:0] b,
                             logic [DUR_W-1:0] span);
        led_cmd_t c;
        c.op    = op;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        c.span  = span;
        cmd_pending.push_back(c);
        queued_cmds++;
    endtask

    function automatic logic [LEVEL_W-1:0] rand_level();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return LEVEL_W'($urandom());
        endcase
    endfunction

    // Mostly short spans so fades run out and blinks toggle within a scene
    function automatic logic [DUR_W-1:0] rand_span();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom();
            2:       return '1;
            3, 4:    return $urandom_range(17, 300);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] rand_word();
        return $urandom();
    endfunction

    // One scene: set a colour, start a fade, a blink or both (or noise), tick through it, maybe clear
    task automatic queue_scene();
        int               kind;
        int               n_ticks;
        logic [DUR_W-1:0] span;
        kind = $urandom_range(0, 9);
        span = rand_span();
        queue_cmd(OP_SET, rand_level(), rand_level(), rand_level(), rand_word());
        if (kind < 4)
        begin
            queue_cmd(OP_FADE, rand_level(), rand_level(), rand_level(), span);
        end
        else if (kind < 7)
        begin
            queue_cmd(OP_BLINK, rand_level(), rand_level(), rand_level(), span);
        end
        else if (kind < 8)
        begin
            queue_cmd(OP_BLINK, rand_level(), rand_level(), rand_level(), span);
            repeat ($urandom_range(0, 4))
            begin
                queue_cmd(OP_TICK, rand_level(), rand_level(), rand_level(), rand_word());
            end
            queue_cmd(OP_FADE, rand_level(), rand_level(), rand_level(), rand_span());
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                queue_cmd(OPC_W'($urandom_range(OP_TICK, OP_SPARE_LAST)), rand_level(),
                          rand_level(), rand_level(), rand_span());
            end
        end
        n_ticks = $urandom_range(1, (span < 20) ? int'(span) + 4 : 24);
        repeat (n_ticks)
        begin
            queue_cmd(OP_TICK, rand_level(), rand_level(), rand_level(), rand_word());
        end
        if ($urandom_range(0, 3) == 0)
        begin
            queue_cmd(OP_CLEAR, rand_level(), rand_level(), rand_level(), rand_word());
        end
    endtask

    // Write the enable register once every outstanding transaction has completed
    task automatic set_led_enabled(logic en);
        while (cmd_pending.size() != 0 || s_tvalid || led_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_wdata <= en;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_led_enabled(1'b1);
        queue_cmd(OP_SET, 8'hff, 8'hff, 8'hff, 32'hffff_ffff);
        queue_cmd(OP_SET, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
        queue_cmd(OP_SET, 8'hff, 8'h80, 8'h01, 32'h0000_0000);
        queue_cmd(OP_FADE, 8'h00, 8'h00, 8'h00, 32'd2);
        // third tick runs past the fade length and blanks the LED
        repeat (3) queue_cmd(OP_TICK, 8'hff, 8'hff, 8'hff, 32'hffff_ffff);
        queue_cmd(OP_SET, 8'h55, 8'haa, 8'hff, 32'h0000_0000);
        queue_cmd(OP_BLINK, 8'h00, 8'h00, 8'h00, 32'd2);
        repeat (3) queue_cmd(OP_TICK, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
        // zero-length fade leaves the blink running
        queue_cmd(OP_FADE, 8'h00, 8'h00, 8'h00, 32'd0);
        queue_cmd(OP_TICK, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
        queue_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
        queue_cmd(OP_SPARE_FIRST, 8'hff, 8'hff, 8'hff, 32'hffff_ffff);
        queue_cmd(OP_SPARE_LAST, 8'hff, 8'hff, 8'hff, 32'hffff_ffff);
        queue_cmd(OP_SET, 8'h10, 8'h20, 8'h30, 32'h0000_0000);

        // disabled: ticks only count, set is dropped, fade and clear still act
        set_led_enabled(1'b0);
        queue_cmd(OP_TICK, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
        queue_cmd(OP_SET, 8'hff, 8'hff, 8'hff, 32'h0000_0001);
        queue_cmd(OP_FADE, 8'h00, 8'h00, 8'h00, 32'd3);
        queue_cmd(OP_TICK, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
        queue_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 32'h0000_0000);

        for (int phase = 0; phase < 7; phase++)
        begin
            set_led_enabled((phase == 0) || ($urandom_range(0, 3) != 0));
            queued_cmds = 0;
            while (queued_cmds < 160)
            begin
                queue_scene();
            end
        end

        while (cmd_pending.size() != 0 || s_tvalid || led_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
